// File: rtl/fark_pkg.sv
// ----------------------------------------------------------------------------
// fark_pkg
// shared widths and command codes of the farey angle rank table
// ----------------------------------------------------------------------------
package fark_pkg;

    localparam int ORDER_W = 7;   // order register
    localparam int COORD_W = 8;   // coordinate fields, two's complement
    localparam int CW      = 9;   // internal signed coordinate width
    localparam int RANK_W  = 14;  // stored rank
    localparam int HALF_W  = 12;  // rank counter and half span
    localparam int ARW     = 16;  // walk arithmetic width

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

// File: rtl/fark_ram.sv
// ----------------------------------------------------------------------------
// fark_ram
// rank store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fark_ram #(
    parameter int DEPTH  = 16641,
    parameter int ADDR_W = 15
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [fark_pkg::RANK_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [fark_pkg::RANK_W-1:0] rdata
);
    import fark_pkg::*;

    logic [RANK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/farey_angle_rank_table.sv
// ----------------------------------------------------------------------------
// farey_angle_rank_table
// discrete angle rank table over all lattice directions |x|,|y| <= order,
// built from a farey walk and octant mirroring, read back by query
// ----------------------------------------------------------------------------
//
// channel   handshake             payload
// -------   ------------------    ----------------------------------------
// config    cfg_we                cfg_wdata (order)
// input     in_valid / in_ready   command, coord_x, coord_y
// output    out_valid / out_ready rank, out_of_range, last_rank_half
//
// a query is one registered store read, captured into the result registers in S_QRD
// a build takes one clearing sweep over all DEPTH entries, then the farey walk
// (one store write per put plus subtract loops for divide and gcd per term),
// then a read, then a write per mirrored entry on the one store
// after reset the store is swept to zero over all DEPTH entries; in_ready stays low
// one item at a time; a new item is taken while the last result waits only
// when that result leaves in the same cycle
// ----------------------------------------------------------------------------
module farey_angle_rank_table #(
    parameter int ORDER_MAX = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fark_pkg::ORDER_W-1:0] cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [fark_pkg::COORD_W-1:0] coord_x,
    input  logic [fark_pkg::COORD_W-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fark_pkg::RANK_W-1:0]  rank,
    output logic                         out_of_range,
    output logic [fark_pkg::HALF_W-1:0]  last_rank_half
);
    import fark_pkg::*;

    localparam int SPAN   = 2 * ORDER_MAX + 1;
    localparam int DEPTH  = SPAN * SPAN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [CW-1:0] OFF = CW'(ORDER_MAX);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_QRD, S_INIT0, S_INIT1, S_TEST, S_KDIV, S_MULE,
        S_MULF, S_GCD, S_EDIV, S_FDIV, S_CHK, S_MULT, S_HALF, S_MRD, S_MWR
    } state_t;

    typedef enum logic [1:0] {P_OCT, P_LOW, P_NEG_Y, P_NEG_X} phase_t;

    // store address of a direction
    function automatic logic [ADDR_W-1:0] addr_of(input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
        logic [CW-1:0] xo;
        logic [CW-1:0] yo;
        begin
            xo = $unsigned(x + OFF);
            yo = $unsigned(y + OFF);
            return ADDR_W'(ADDR_W'(xo) * ADDR_W'(SPAN)) + ADDR_W'(yo);
        end
    endfunction

    state_t                   state_reg;
    phase_t                   phase_reg, phase_next;
    logic                     build_reg;
    logic [ORDER_W-1:0]       order_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [ORDER_W-1:0]       ln_reg, ld_reg, rn_reg, rd_reg;
    logic [HALF_W-1:0]        rc_reg, half_span_reg;
    logic [ARW-1:0]           dv_rem_reg, dv_d_reg, dv_q_reg;
    logic [ARW-1:0]           e_reg, f_reg, ga_reg, gb_reg;
    logic [CW-1:0]            ex_reg, fy_reg;
    logic signed [CW-1:0]     a_reg, b_reg, a_next, b_next;
    logic                     mirror_done;
    logic                     q_oor_reg;
    logic                     out_valid_reg, oor_reg;
    logic [RANK_W-1:0]        rank_reg;

    logic [ORDER_W-1:0]       n_eff;
    logic signed [CW-1:0]     ns;
    logic signed [CW-1:0]     qx, qy, rx, ry;
    logic                     q_oor;
    logic                     in_fire;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic [RANK_W-1:0]        mem_wdata, mem_rdata;
    logic [ARW-1:0]           fnv, mconst;
    logic [RANK_W-1:0]        mirror_val;

    // effective order, clamped to 1..ORDER_MAX
    always_comb
    begin
        if (order_reg == '0)
            n_eff = ORDER_W'(1);
        else if (order_reg > ORDER_W'(ORDER_MAX))
            n_eff = ORDER_W'(ORDER_MAX);
        else
            n_eff = order_reg;
    end
    assign ns = $signed(CW'(n_eff));

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // query coordinates and span check
    assign qx    = CW'($signed(coord_x));
    assign qy    = CW'($signed(coord_y));
    assign q_oor = (qx < -ns) || (qx > ns) || (qy < -ns) || (qy > ns);

    // mirror source direction per phase
    always_comb
    begin
        case (phase_reg)
            P_OCT:   begin rx = b_reg - a_reg; ry = b_reg;  end
            P_LOW:   begin rx = b_reg;         ry = a_reg;  end
            P_NEG_Y: begin rx = a_reg;         ry = -b_reg; end
            P_NEG_X: begin rx = -a_reg;        ry = b_reg;  end
            default: begin rx = a_reg;         ry = b_reg;  end
        endcase
    end

    // mirror value: phase constant minus source rank
    assign fnv = ARW'(half_span_reg);
    always_comb
    begin
        case (phase_reg)
            P_OCT:   mconst = fnv + ARW'(1);
            P_LOW:   mconst = fnv << 1;
            P_NEG_Y: mconst = (fnv << 2) - ARW'(2);
            P_NEG_X: mconst = (fnv << 3) - ARW'(6);
            default: mconst = '0;
        endcase
    end
    assign mirror_val = RANK_W'(mconst - ARW'(mem_rdata));

    // mirror scan order
    always_comb
    begin
        phase_next  = phase_reg;
        a_next      = a_reg;
        b_next      = b_reg + CW'(1);
        mirror_done = 1'b0;
        case (phase_reg)
            P_OCT:
            begin
                if ((b_reg + CW'(1) > (a_reg <<< 1)) || (b_reg + CW'(1) > ns))
                begin
                    if (a_reg + CW'(1) > ns)
                    begin
                        phase_next = P_LOW;
                        a_next     = CW'(1);
                        b_next     = '0;
                    end
                    else
                    begin
                        a_next = a_reg + CW'(1);
                        b_next = a_reg + CW'(1);
                    end
                end
            end
            P_LOW:
            begin
                if (b_reg + CW'(1) > a_reg - CW'(1))
                begin
                    if (a_reg + CW'(1) > ns)
                    begin
                        phase_next = P_NEG_Y;
                        a_next     = '0;
                        b_next     = -ns;
                    end
                    else
                    begin
                        a_next = a_reg + CW'(1);
                        b_next = '0;
                    end
                end
            end
            P_NEG_Y:
            begin
                if (b_reg == -CW'(1))
                begin
                    if (a_reg + CW'(1) > ns)
                    begin
                        phase_next = P_NEG_X;
                        a_next     = -ns;
                        b_next     = -ns;
                    end
                    else
                    begin
                        a_next = a_reg + CW'(1);
                        b_next = -ns;
                    end
                end
            end
            P_NEG_X:
            begin
                if (b_reg == ns)
                begin
                    if (a_reg == -CW'(1))
                        mirror_done = 1'b1;
                    else
                    begin
                        a_next = a_reg + CW'(1);
                        b_next = -ns;
                    end
                end
            end
            default: mirror_done = 1'b1;
        endcase
    end

    // store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(a_reg, b_reg);
        mem_wdata = '0;
        mem_raddr = addr_of(rx, ry);
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            S_IDLE:  mem_raddr = addr_of(qx, qy);
            S_INIT0:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of('0, b_reg);
                mem_wdata = RANK_W'(1);
            end
            S_INIT1:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(CW'(1), ns);
                mem_wdata = RANK_W'(2);
            end
            S_MULT:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of($signed(ex_reg), $signed(fy_reg));
                mem_wdata = RANK_W'(rc_reg);
            end
            S_MWR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mirror_val;
            end
            default: mem_we = 1'b0;
        endcase
    end

    fark_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= P_OCT;
            build_reg     <= 1'b0;
            order_reg     <= ORDER_W'(8);
            clr_cnt_reg   <= '0;
            ln_reg        <= '0;
            ld_reg        <= ORDER_W'(1);
            rn_reg        <= ORDER_W'(1);
            rd_reg        <= ORDER_W'(8);
            rc_reg        <= HALF_W'(2);
            half_span_reg <= '0;
            dv_rem_reg    <= '0;
            dv_d_reg      <= '0;
            dv_q_reg      <= '0;
            e_reg         <= '0;
            f_reg         <= '0;
            ga_reg        <= '0;
            gb_reg        <= '0;
            ex_reg        <= '0;
            fy_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            q_oor_reg     <= 1'b0;
            oor_reg       <= 1'b0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                order_reg <= cfg_wdata;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        clr_cnt_reg <= '0;
                        if (build_reg)
                        begin
                            ln_reg    <= '0;
                            ld_reg    <= ORDER_W'(1);
                            rn_reg    <= ORDER_W'(1);
                            rd_reg    <= n_eff;
                            rc_reg    <= HALF_W'(2);
                            b_reg     <= CW'(1);
                            state_reg <= S_INIT0;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (command == CMD_QUERY)
                        begin
                            q_oor_reg <= q_oor;
                            state_reg <= S_QRD;
                        end
                        else
                        begin
                            build_reg <= 1'b1;
                            state_reg <= S_CLEAR;
                        end
                    end
                end
                S_QRD:
                begin
                    rank_reg      <= q_oor_reg ? '0 : mem_rdata;
                    oor_reg       <= q_oor_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_INIT0:
                begin
                    b_reg <= b_reg + CW'(1);
                    if (b_reg == ns)
                        state_reg <= S_INIT1;
                end
                S_INIT1: state_reg <= S_TEST;
                S_TEST:
                begin
                    if ({1'b0, rn_reg, 1'b0} < {2'b0, rd_reg})
                    begin
                        rc_reg     <= rc_reg + HALF_W'(1);
                        dv_rem_reg <= ARW'(n_eff) + ARW'(ld_reg);
                        dv_d_reg   <= ARW'(rd_reg);
                        dv_q_reg   <= '0;
                        state_reg  <= S_KDIV;
                    end
                    else
                        state_reg <= S_HALF;
                end
                S_KDIV:
                begin
                    if (dv_rem_reg >= dv_d_reg)
                    begin
                        dv_rem_reg <= dv_rem_reg - dv_d_reg;
                        dv_q_reg   <= dv_q_reg + ARW'(1);
                    end
                    else
                        state_reg <= S_MULE;
                end
                S_MULE:
                begin
                    e_reg     <= ARW'(dv_q_reg * ARW'(rn_reg)) - ARW'(ln_reg);
                    state_reg <= S_MULF;
                end
                S_MULF:
                begin
                    f_reg     <= ARW'(dv_q_reg * ARW'(rd_reg)) - ARW'(ld_reg);
                    ga_reg    <= e_reg;
                    gb_reg    <= ARW'(dv_q_reg * ARW'(rd_reg)) - ARW'(ld_reg);
                    state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    // subtractive euclid
                    if (gb_reg != '0)
                    begin
                        if (ga_reg >= gb_reg)
                            ga_reg <= ga_reg - gb_reg;
                        else
                        begin
                            ga_reg <= gb_reg;
                            gb_reg <= ga_reg;
                        end
                    end
                    else
                    begin
                        dv_d_reg   <= (ga_reg == '0) ? ARW'(1) : ga_reg;
                        dv_rem_reg <= e_reg;
                        dv_q_reg   <= '0;
                        state_reg  <= S_EDIV;
                    end
                end
                S_EDIV:
                begin
                    if (dv_rem_reg >= dv_d_reg)
                    begin
                        dv_rem_reg <= dv_rem_reg - dv_d_reg;
                        dv_q_reg   <= dv_q_reg + ARW'(1);
                    end
                    else
                    begin
                        e_reg      <= dv_q_reg;
                        dv_rem_reg <= f_reg;
                        dv_q_reg   <= '0;
                        state_reg  <= S_FDIV;
                    end
                end
                S_FDIV:
                begin
                    if (dv_rem_reg >= dv_d_reg)
                    begin
                        dv_rem_reg <= dv_rem_reg - dv_d_reg;
                        dv_q_reg   <= dv_q_reg + ARW'(1);
                    end
                    else
                    begin
                        f_reg     <= dv_q_reg;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if ((f_reg == '0) || (f_reg > ARW'(n_eff)))
                        state_reg <= S_HALF;
                    else
                    begin
                        ex_reg    <= CW'(e_reg);
                        fy_reg    <= CW'(f_reg);
                        state_reg <= S_MULT;
                    end
                end
                S_MULT:
                begin
                    // every multiple of the term inside the span
                    ex_reg <= ex_reg + CW'(e_reg);
                    fy_reg <= fy_reg + CW'(f_reg);
                    if (fy_reg + CW'(f_reg) > CW'(n_eff))
                    begin
                        ln_reg    <= rn_reg;
                        ld_reg    <= rd_reg;
                        rn_reg    <= ORDER_W'(e_reg);
                        rd_reg    <= ORDER_W'(f_reg);
                        state_reg <= S_TEST;
                    end
                end
                S_HALF:
                begin
                    half_span_reg <= (rc_reg << 1) - HALF_W'(1);
                    phase_reg     <= P_OCT;
                    a_reg         <= CW'(1);
                    b_reg         <= CW'(1);
                    state_reg     <= S_MRD;
                end
                S_MRD: state_reg <= S_MWR;
                S_MWR:
                begin
                    phase_reg <= phase_next;
                    a_reg     <= a_next;
                    b_reg     <= b_next;
                    if (mirror_done)
                    begin
                        build_reg     <= 1'b0;
                        rank_reg      <= '0;
                        oor_reg       <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_MRD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign rank           = rank_reg;
    assign out_of_range   = oor_reg;
    assign last_rank_half = half_span_reg;

endmodule

// File: tb/farey_angle_rank_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farey_angle_rank_table_tb
// self-checking bench for the farey angle rank table: a local copy of the
// table is built alongside the block from the same order register, every
// query and build result is compared field by field, with random gaps on
// the input side and random stalls on the result side
// ----------------------------------------------------------------------------
module farey_angle_rank_table_tb;

    import fark_pkg::*;

    localparam int ORDER_MAX  = 64;
    localparam int SPAN       = 2 * ORDER_MAX + 1;
    localparam int DEPTH      = SPAN * SPAN;
    localparam int STALL_MAX  = 1000000;  // watchdog limit, above the length of a full build at order 64
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              oor;
        logic [HALF_W-1:0] half;
    } rank_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ORDER_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic                out_valid;
    logic                out_ready;
    logic [RANK_W-1:0]   rank;
    logic                out_of_range;
    logic [HALF_W-1:0]   last_rank_half;

    // local copy of the block state
    logic [RANK_W-1:0]   rank_mem [0:DEPTH-1];
    int                  order_reg;
    int                  half_span_q;

    rank_result_t        pending_ranks [$];
    int                  err_count;
    int                  quiet_cycles;
    bit                  calm;           // no idling on either side

    farey_angle_rank_table #(.ORDER_MAX(ORDER_MAX)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rank           (rank),
        .out_of_range   (out_of_range),
        .last_rank_half (last_rank_half)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------

    // order 0 behaves as 1, anything above the maximum as the maximum
    function automatic int eff_order();
        int o;
        o = order_reg & 'h7F;
        if (o < 1)
            o = 1;
        if (o > ORDER_MAX)
            o = ORDER_MAX;
        return o;
    endfunction

    function automatic int cell_addr(int x, int y);
        return (x + ORDER_MAX) * SPAN + (y + ORDER_MAX);
    endfunction

    function automatic int rd(int x, int y);
        int a;
        a = cell_addr(x, y);
        if (a >= 0 && a < DEPTH)
            return int'(rank_mem[a]);
        return 0;
    endfunction

    function automatic void wr(int x, int y, int v);
        int a;
        a = cell_addr(x, y);
        if (a >= 0 && a < DEPTH)
            rank_mem[a] = v[RANK_W-1:0];
    endfunction

    function automatic int gcd_of(int a, int b);
        int t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // farey walk up to 1/2, then mirror into the remaining octants
    function automatic void rebuild_ranks();
        int n, ln, ld, rn, rd_, cnt, k, e, f, g, fnv, a, b, i;
        n = eff_order();
        for (i = 0; i < DEPTH; i++)
            rank_mem[i] = '0;
        ln = 0; ld = 1; rn = 1; rd_ = n;
        cnt = 2;
        for (i = 1; i <= n; i++)
            wr(0, i, 1);
        wr(1, n, 2);
        while (2 * rn < rd_)
        begin
            cnt = (cnt + 1) & 'hFFF;
            k = (n + ld) / rd_;
            e = k * rn - ln;
            f = k * rd_ - ld;
            g = gcd_of(e, f);
            if (g == 0)
                g = 1;
            e = e / g;
            f = f / g;
            if (f == 0 || f > n)
                break;
            for (i = 1; i <= n / f; i++)
                wr(e * i, f * i, cnt);
            ln = rn; ld = rd_; rn = e; rd_ = f;
        end
        half_span_q = (2 * cnt - 1) & 'hFFF;
        fnv = half_span_q;
        for (a = 1; a <= n; a++)
            for (b = a; (b + 1) / 2 <= a && b <= n; b++)
                wr(a, b, fnv + 1 - rd(b - a, b));
        for (a = 1; a <= n; a++)
            for (b = 0; b <= a - 1; b++)
                wr(a, b, 2 * fnv - rd(b, a));
        for (a = 0; a <= n; a++)
            for (b = -n; b <= -1; b++)
                wr(a, b, 4 * fnv - 2 - rd(a, -b));
        for (a = -n; a <= -1; a++)
            for (b = -n; b <= -1; b++)
                wr(a, b, 8 * fnv - 6 - rd(-a, b));
        for (a = -n; a <= -1; a++)
            for (b = 0; b <= n; b++)
                wr(a, b, 8 * fnv - 6 - rd(-a, b));
    endfunction

    function automatic rank_result_t predict_rank(logic cmd, int x, int y);
        rank_result_t r;
        int n;
        r = '0;
        if (cmd == CMD_BUILD)
        begin
            rebuild_ranks();
        end
        else
        begin
            n = eff_order();
            if (x < -n || x > n || y < -n || y > n)
                r.oor = 1'b1;
            else
                r.rank = RANK_W'(rd(x, y));
        end
        r.half = half_span_q[HALF_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 30);
    endfunction

    // one item: random gap, then hold until accepted, expectation on accept
    task automatic send_item(logic cmd, int x, int y);
        while (idle_now())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        coord_x  = x[COORD_W-1:0];
        coord_y  = y[COORD_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        pending_ranks.insert(pending_ranks.size(), predict_rank(cmd, x, y));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic query(int x, int y);
        send_item(CMD_QUERY, x, y);
    endtask

    task automatic build();
        send_item(CMD_BUILD, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic drain();
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    // register written only with nothing in flight
    task automatic set_order(int v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v[ORDER_W-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        order_reg = v & 'h7F;
    endtask

    task automatic rand_query(int n);
        if ($urandom_range(0, 99) < 80)
            query($urandom_range(0, 2 * n) - n, $urandom_range(0, 2 * n) - n);
        else
            query($urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64);
    endtask

    // result side stalls at random
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 30);

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(string field, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        rank_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ranks.size() == 0)
            begin
                report("unexpected result count", 1, 0);
            end
            else
            begin
                want = pending_ranks.pop_front();
                if (rank !== want.rank)
                    report("rank", rank, want.rank);
                if (out_of_range !== want.oor)
                    report("out_of_range", out_of_range, want.oor);
                if (last_rank_half !== want.half)
                    report("last_rank_half", last_rank_half, want.half);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("farey_angle_rank_table regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // store is all zero and half span zero before any build
    task automatic test_before_build();
        query(0, 0);
        query(8, -8);
        query(-8, 3);
        query(9, 0);
        query(0, -9);
    endtask

    // default order: corners, axes, origin, just outside and far outside the span
    task automatic test_default_order();
        build();
        query(0, 0);
        query(0, 8);
        query(1, 8);
        query(8, 8);
        query(-8, -8);
        query(8, -8);
        query(-8, 8);
        query(4, 8);
        query(-1, 0);
        query(9, 9);
        query(-9, 0);
        query(-64, 64);
        query(64, -64);
    endtask

    // order 1 and 2 stop the walk at 1/n; order 0 clamps to 1
    task automatic test_small_orders();
        set_order(1);
        build();
        query(1, 1);
        query(-1, 0);
        query(2, 0);
        set_order(2);
        build();
        query(1, 2);
        query(-2, -1);
        set_order(0);
        query(1, 1);      // stale table, order now clamps to 1
        query(2, 2);
        build();
        query(-1, -1);
    endtask

    // order above the maximum clamps, then full-span corners
    task automatic test_max_order();
        set_order(127);
        build();
        query(64, 64);
        query(-64, -64);
        query(64, -1);
        query(-64, 0);
        query(1, 2);
        set_order(64);
        query(-64, 64);
        query(0, 0);
    endtask

    task automatic test_random(int total);
        int per, n, r;
        per = total / 10;
        for (r = 0; r < 10; r++)
        begin
            case (r)
                0: set_order(3);
                4: set_order(ORDER_MAX);
                default:
                    if ($urandom_range(0, 2) == 0)
                        set_order($urandom_range(0, 127));
                    else
                        set_order($urandom_range(1, 16));
            endcase
            calm = (r == 2);
            n = eff_order();
            // a few reads of the stale table before rebuilding
            repeat (5) rand_query(n);
            build();
            repeat (per - 6) rand_query(n);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        command   = CMD_QUERY;
        coord_x   = '0;
        coord_y   = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        err_count = 0;
        quiet_cycles = 0;
        order_reg   = 8;
        half_span_q = 0;
        for (int i = 0; i < DEPTH; i++)
            rank_mem[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_before_build();
        test_default_order();
        test_small_orders();
        test_max_order();
        test_random(1150);

        drain();
        if (err_count == 0)
            $display("farey_angle_rank_table regression: pass");
        else
            $display("farey_angle_rank_table regression: fail");
        $finish;
    end

endmodule

// File: farey_angle_rank_table.f
rtl/fark_pkg.sv
rtl/fark_ram.sv
rtl/farey_angle_rank_table.sv
tb/farey_angle_rank_table_tb.sv
